@@ hw/rtl/crtc_pkg.sv @@
package crtc_pkg;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [31:0] RESET_EPOCH = 32'd1217647125;
    localparam logic [7:0]  RESET_TPS   = 8'd100;
    localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
    localparam logic [31:0] DAY_OFFSET  = 32'd719499;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    // Reciprocals for exact division by multiplication over the operand ranges used.
    // Days: (t >> 7) / 675. Weekday: x / 7. Hours: (s >> 4) / 225. Minutes: (s >> 2) / 15.
    localparam logic [25:0] RECIP_DAY   = 26'd50903317;
    localparam int          DAY_SHIFT   = 35;
    localparam logic [16:0] RECIP_WEEK  = 17'd74899;
    localparam int          WEEK_SHIFT  = 19;
    localparam logic [12:0] RECIP_HOUR  = 13'd4661;
    localparam int          HOUR_SHIFT  = 20;
    localparam logic [10:0] RECIP_MIN   = 11'd1093;
    localparam int          MIN_SHIFT   = 14;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] set_year;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } crtc_in_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } crtc_out_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_SET_Y, OP_SET_D, OP_SET_H, OP_SET_MI, OP_SET_S,
        OP_CONV, OP_WALK_INIT, OP_YEAR, OP_MONTH, OP_RESULT
    } dp_op_t;

    typedef enum logic [2:0] {
        CV_DAYS, CV_SPLIT, CV_HOUR, CV_SOH, CV_MIN
    } conv_step_t;

    typedef struct packed {
        dp_op_t     op;
        conv_step_t sel;
    } crtc_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_busy;
    } crtc_stat_t;

    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd305;
            4'd1:    r = 9'd336;
            4'd2:    r = 9'd367;
            4'd3:    r = 9'd30;
            4'd4:    r = 9'd61;
            4'd5:    r = 9'd91;
            4'd6:    r = 9'd122;
            4'd7:    r = 9'd152;
            4'd8:    r = 9'd183;
            4'd9:    r = 9'd214;
            4'd10:   r = 9'd244;
            4'd11:   r = 9'd275;
            4'd12:   r = 9'd305;
            4'd13:   r = 9'd336;
            4'd14:   r = 9'd367;
            4'd15:   r = 9'd397;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: r = 5'd31;
            4'd1:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd30;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/crtc_ctrl.sv @@
module crtc_ctrl
    import crtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_cmd,
    input  crtc_stat_t stat,
    output logic       s_ready,
    output crtc_cmd_t  ctl
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_SET_Y  = 11'b00000000010,
        ST_SET_D  = 11'b00000000100,
        ST_SET_H  = 11'b00000001000,
        ST_SET_MI = 11'b00000010000,
        ST_SET_S  = 11'b00000100000,
        ST_CONV   = 11'b00001000000,
        ST_WINIT  = 11'b00010000000,
        ST_YEAR   = 11'b00100000000,
        ST_MONTH  = 11'b01000000000,
        ST_RESULT = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    conv_step_t sel_reg, sel_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ctl.op     = OP_NONE;
        ctl.sel    = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.op = OP_ACCEPT;
                    if (s_cmd == CMD_SET) begin
                        state_next = ST_SET_Y;
                    end else if (s_cmd == CMD_READ) begin
                        state_next = ST_CONV;
                        sel_next   = CV_DAYS;
                    end
                end
            end
            ST_SET_Y: begin
                ctl.op = OP_SET_Y;
                state_next = ST_SET_D;
            end
            ST_SET_D: begin
                ctl.op = OP_SET_D;
                state_next = ST_SET_H;
            end
            ST_SET_H: begin
                ctl.op = OP_SET_H;
                state_next = ST_SET_MI;
            end
            ST_SET_MI: begin
                ctl.op = OP_SET_MI;
                state_next = ST_SET_S;
            end
            ST_SET_S: begin
                ctl.op = OP_SET_S;
                state_next = ST_IDLE;
            end
            ST_CONV: begin
                ctl.op = OP_CONV;
                if (sel_reg == CV_MIN) begin
                    state_next = ST_WINIT;
                end else begin
                    sel_next = conv_step_t'(sel_reg + 3'd1);
                end
            end
            ST_WINIT: begin
                ctl.op = OP_WALK_INIT;
                state_next = ST_YEAR;
            end
            ST_YEAR: begin
                ctl.op = OP_YEAR;
                if (stat.year_done) begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                ctl.op = OP_MONTH;
                if (stat.month_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!stat.out_busy) begin
                    ctl.op = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= CV_DAYS;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

`ifndef SYNTHESIS
    a_conv_to_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV && sel_reg == CV_MIN) |=> state_reg == ST_WINIT)
        else $error("time split did not end in the calendar walk");
    a_year_to_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_YEAR && stat.year_done) |=> state_reg == ST_MONTH)
        else $error("year walk did not hand over to month walk");
    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESULT && !stat.out_busy) |=> state_reg == ST_IDLE)
        else $error("result was not stored when the output was free");
`endif

endmodule

@@ hw/rtl/crtc_dp.sv @@
module crtc_dp
    import crtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  crtc_in_t   s_data,
    input  crtc_cmd_t  ctl,
    input  logic       m_ready,
    output crtc_stat_t stat,
    output logic       m_valid,
    output crtc_out_t  m_data
);

    logic [7:0]  tps_reg, sub_reg;
    logic [31:0] epoch_reg;
    crtc_in_t    in_reg;
    logic [12:0] ya_reg;
    logic [24:0] prod_reg;
    logic [31:0] acc_reg;
    logic [16:0] sod_reg;
    logic [11:0] soh_reg;
    logic [13:0] q7_reg;
    logic [15:0] days_reg;
    logic [2:0]  wd_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  min_reg, sec_reg;
    logic [11:0] y_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  mon_reg;
    crtc_out_t   out_reg;
    logic        out_valid_reg;

    logic [7:0]  sub_inc;
    logic [12:0] ya_in;
    logic [11:0] yp_in, yp;
    logic [5:0]  q100;
    logic [31:0] days_calc;
    logic [50:0] day_prod;
    logic [15:0] wk_sum, wd_calc;
    logic [32:0] wk_prod;
    logic [25:0] hr_prod;
    logic [16:0] soh_calc;
    logic [20:0] mn_prod;
    logic [11:0] sec_calc;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    assign sub_inc = sub_reg + 8'd1;
    assign ya_in = (in_reg.set_month <= 4'd2) ? ({1'b0, in_reg.set_year} - 13'd1)
                                              : {1'b0, in_reg.set_year};
    assign yp_in = ya_in[12] ? 12'd0 : ya_in[11:0];
    assign yp    = ya_reg[12] ? 12'd0 : ya_reg[11:0];
    assign q100  = prod_reg[RECIP_SHIFT +: 6];
    assign days_calc = 32'(yp >> 2) - 32'(q100) + 32'(q100 >> 2)
                     + 32'(month_offset(in_reg.set_month)) + 32'(in_reg.set_day)
                     + 32'($signed({{19{ya_reg[12]}}, ya_reg}) * 32'sd365)
                     - DAY_OFFSET;

    assign day_prod = 51'(epoch_reg[31:7]) * 51'(RECIP_DAY);
    assign wk_sum   = days_reg + 16'd4;
    assign wk_prod  = 33'(wk_sum) * 33'(RECIP_WEEK);
    assign wd_calc  = wk_sum - 16'(q7_reg) * 16'(DAYS_PER_WEEK);
    assign hr_prod  = 26'(sod_reg[16:4]) * 26'(RECIP_HOUR);
    assign soh_calc = sod_reg - 17'(hour_reg) * 17'(SECS_PER_HOUR);
    assign mn_prod  = 21'(soh_reg[11:2]) * 21'(RECIP_MIN);
    assign sec_calc = soh_reg - 12'(min_reg) * 12'(SECS_PER_MIN);

    assign leap  = (y_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign ylen  = leap ? 9'd366 : 9'd365;
    assign mlen  = days_in_month(mon_reg, leap);

    assign stat.year_done  = (days_reg < 16'(ylen));
    assign stat.month_done = (mon_reg == 4'd11) || (days_reg < 16'(mlen));
    assign stat.out_busy   = out_valid_reg && !m_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg       <= RESET_TPS;
            sub_reg       <= '0;
            epoch_reg     <= RESET_EPOCH;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tps_reg <= cfg_wr_data;
            end
            if (ctl.op == OP_RESULT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (ctl.op)
                OP_ACCEPT: begin
                    in_reg <= s_data;
                    if (s_data.cmd == CMD_TICK) begin
                        if (sub_inc == tps_reg) begin
                            sub_reg   <= '0;
                            epoch_reg <= epoch_reg + 32'd1;
                        end else begin
                            sub_reg <= sub_inc;
                        end
                    end
                end
                OP_SET_Y: begin
                    ya_reg   <= ya_in;
                    prod_reg <= 25'(yp_in * RECIP_100);
                end
                OP_SET_D: begin
                    acc_reg <= days_calc;
                end
                OP_SET_H: begin
                    acc_reg <= 32'(acc_reg * 32'd24) + 32'(in_reg.set_hour);
                end
                OP_SET_MI: begin
                    acc_reg <= 32'(acc_reg * 32'd60) + 32'(in_reg.set_minute);
                end
                OP_SET_S: begin
                    epoch_reg <= 32'(acc_reg * 32'd60) + 32'(in_reg.set_second);
                end
                OP_CONV: begin
                    case (ctl.sel)
                        CV_DAYS: begin
                            days_reg <= day_prod[DAY_SHIFT +: 16];
                        end
                        CV_SPLIT: begin
                            sod_reg <= 17'(epoch_reg - 32'(days_reg) * 32'(SECS_PER_DAY));
                            q7_reg  <= wk_prod[WEEK_SHIFT +: 14];
                        end
                        CV_HOUR: begin
                            wd_reg   <= wd_calc[2:0];
                            hour_reg <= hr_prod[HOUR_SHIFT +: 5];
                        end
                        CV_SOH: begin
                            soh_reg <= soh_calc[11:0];
                        end
                        CV_MIN: begin
                            min_reg <= mn_prod[MIN_SHIFT +: 6];
                        end
                        default: begin
                        end
                    endcase
                end
                OP_WALK_INIT: begin
                    sec_reg  <= sec_calc[5:0];
                    y_reg    <= EPOCH_YEAR;
                    c100_reg <= 7'd70;
                    c400_reg <= 9'd370;
                    mon_reg  <= '0;
                end
                OP_YEAR: begin
                    if (!stat.year_done) begin
                        days_reg <= days_reg - 16'(ylen);
                        y_reg    <= y_reg + 12'd1;
                        c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                        c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                    end
                end
                OP_MONTH: begin
                    if (!stat.month_done) begin
                        days_reg <= days_reg - 16'(mlen);
                        mon_reg  <= mon_reg + 4'd1;
                    end
                end
                OP_RESULT: begin
                    out_reg.year    <= y_reg;
                    out_reg.month   <= mon_reg + 4'd1;
                    out_reg.day     <= days_reg[4:0] + 5'd1;
                    out_reg.hour    <= hour_reg;
                    out_reg.minute  <= min_reg;
                    out_reg.second  <= sec_reg;
                    out_reg.weekday <= wd_reg;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/calendar_rtc_with_prescaler_unit.sv @@
// A tick or an unused command is taken without leaving the idle state; a set builds the
// seconds count from the year, day, hour, minute and second in turn. A read splits the
// seconds count into days, weekday, hours, minutes and seconds, then walks years from 1970
// and then months.
// One item is in work at a time; the input is ready again in the cycle after a result is stored.
// Reset (aresetn, synchronous, active low) loads 1217647125 seconds, clears the prescaler
// and sets ticks_per_second to 100.
module calendar_rtc_with_prescaler_unit
    import crtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  crtc_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output crtc_out_t  m_data
);

    crtc_cmd_t  ctl;
    crtc_stat_t stat;

    crtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .stat    (stat),
        .s_ready (s_ready),
        .ctl     (ctl)
    );

    crtc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .ctl         (ctl),
        .m_ready     (m_ready),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule

@@ tb/crtc_checker.sv @@
`timescale 1ns / 1ps

module crtc_checker
    import crtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  crtc_in_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  crtc_out_t  m_data,
    output int         pending_dates,
    output int         error_count
);

    logic [7:0]  tick_limit;
    logic [7:0]  prescale;
    logic [31:0] seconds_now;
    crtc_out_t   date_queue[$];

    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic logic [31:0] seconds_of_date(input crtc_in_t it);
        longint y, m, d, h, mi, s, days, total;
        y = it.set_year;
        m = it.set_month;
        d = it.set_day;
        h = it.set_hour;
        mi = it.set_minute;
        s = it.set_second;
        if (m <= 2) begin
            m += 10;
            y -= 1;
        end else begin
            m -= 2;
        end
        days = y / 4 - y / 100 + y / 400 + (367 * m) / 12 + d + y * 365 - 719499;
        total = ((days * 24 + h) * 60 + mi) * 60 + s;
        return total[31:0];
    endfunction

    function automatic crtc_out_t date_of_seconds(input logic [31:0] t);
        crtc_out_t   r;
        int unsigned rest, days, y, m, len;
        int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        rest = t;
        r.second = 6'(rest % 60);
        rest = rest / 60;
        r.minute = 6'(rest % 60);
        rest = rest / 60;
        r.hour = 5'(rest % 24);
        days = rest / 24;
        r.weekday = 3'((days + 4) % 7);
        y = 1970;
        forever begin
            len = is_leap(y) ? 366 : 365;
            if (days < len) break;
            days -= len;
            y++;
        end
        for (m = 0; m < 11; m++) begin
            len = mlen[m];
            if (m == 1 && is_leap(y)) len++;
            if (days < len) break;
            days -= len;
        end
        r.year = 12'(y);
        r.month = 4'(m + 1);
        r.day = 5'(days + 1);
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        crtc_out_t want;
        if (!aresetn) begin
            tick_limit  <= RESET_TPS;
            prescale    <= 8'd0;
            seconds_now <= RESET_EPOCH;
            error_count = 0;
            date_queue.delete();
        end else begin
            if (cfg_wr_en) tick_limit <= cfg_wr_data;
            if (s_valid && s_ready) begin
                case (s_data.cmd)
                    CMD_TICK: begin
                        if (prescale + 8'd1 == tick_limit) begin
                            prescale    <= 8'd0;
                            seconds_now <= seconds_now + 32'd1;
                        end else begin
                            prescale <= prescale + 8'd1;
                        end
                    end
                    CMD_SET:  seconds_now <= seconds_of_date(s_data);
                    CMD_READ: date_queue.push_back(date_of_seconds(seconds_now));
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (date_queue.size() == 0) begin
                    report("result count", 1, 0);
                end else begin
                    want = date_queue.pop_front();
                    if (m_data.year !== want.year)
                        report("year", int'(m_data.year), int'(want.year));
                    if (m_data.month !== want.month)
                        report("month", int'(m_data.month), int'(want.month));
                    if (m_data.day !== want.day)
                        report("day", int'(m_data.day), int'(want.day));
                    if (m_data.hour !== want.hour)
                        report("hour", int'(m_data.hour), int'(want.hour));
                    if (m_data.minute !== want.minute)
                        report("minute", int'(m_data.minute), int'(want.minute));
                    if (m_data.second !== want.second)
                        report("second", int'(m_data.second), int'(want.second));
                    if (m_data.weekday !== want.weekday)
                        report("weekday", int'(m_data.weekday), int'(want.weekday));
                end
            end
        end
        pending_dates <= date_queue.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import crtc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT = 4000000;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    crtc_in_t   s_data;
    logic       m_valid;
    logic       m_ready = 1'b0;
    crtc_out_t  m_data;
    int         pending_dates;
    int         error_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         cycles = 0;

    calendar_rtc_with_prescaler_unit uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    crtc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .pending_dates(pending_dates), .error_count(error_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic crtc_in_t make_item(input logic [1:0] c, input int y, input int mo,
                                           input int d, input int h, input int mi,
                                           input int s);
        crtc_in_t it;
        it.cmd = c;
        it.set_year = 12'(y);
        it.set_month = 4'(mo);
        it.set_day = 5'(d);
        it.set_hour = 5'(h);
        it.set_minute = 6'(mi);
        it.set_second = 6'(s);
        return it;
    endfunction

    function automatic crtc_in_t random_item();
        crtc_in_t it;
        int pick;
        it = crtc_in_t'(40'({$urandom, $urandom}));
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.cmd = CMD_TICK;
        end else if (pick < 60) begin
            it.cmd = CMD_SET;
            if ($urandom_range(9) != 0) begin
                it.set_year = 12'($urandom_range(2105, 1970));
                it.set_month = 4'($urandom_range(12, 1));
                it.set_day = 5'($urandom_range(28, 1));
                it.set_hour = 5'($urandom_range(23));
                it.set_minute = 6'($urandom_range(59));
                it.set_second = 6'($urandom_range(59));
            end
        end else if (pick < 96) begin
            it.cmd = CMD_READ;
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic send(input crtc_in_t it);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    task automatic write_tick_limit(input logic [7:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_dates != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input logic [7:0] limit, input int count);
        write_tick_limit(limit);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_dates != 0) @(posedge aclk);
            end
            send(random_item());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'd0;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 7;
        recv_idle_pct = 67;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_SET, 1970, 1, 1, 0, 0, 0));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_SET, 2000, 2, 29, 23, 59, 59));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_SET, 2100, 3, 1, 12, 30, 30));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_UNUSED, 4095, 15, 31, 31, 63, 63));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_SET, 4095, 15, 31, 31, 63, 63));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_SET, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_SET, 1969, 2, 31, 0, 0, 0));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_TICK, 4095, 15, 31, 31, 63, 63));
        write_tick_limit(8'd1);
        send(make_item(CMD_SET, 2106, 2, 7, 6, 28, 15));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0));
        send(make_item(CMD_READ, 0, 0, 0, 0, 0, 0));

        random_phase(8'd0, 300);
        random_phase(8'd255, 150);
        send_idle_pct = 67;
        recv_idle_pct = 7;
        random_phase(8'd1, 250);
        random_phase(8'($urandom_range(254, 2)), 150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(8'd3, 200);
        random_phase(RESET_TPS, 200);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_dates != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
